// ----- design/bffa_pkg.sv -----
// Shared types and constants for the bitmap first-free allocator.
// Holds the item structs, the row-search result struct and default sizes.
// No dependencies.
package bffa_pkg;

	// Default sizes of one partition bitmap and of the partition count.
	localparam int BITMAP_BYTES_DEF    = 8192;
	localparam int PARTITION_COUNT_DEF = 4;

	// Fixed field widths of the items.
	localparam int PART_W  = 2;
	localparam int INDEX_W = 13;
	localparam int SLOT_W  = 17;

	// One memory row holds eight bitmap bytes, one per byte lane.
	localparam int LANES  = 8;
	localparam int LANE_W = 3;

	// Operation codes of an input item.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Input item.
	typedef struct packed {
		logic               operation;
		logic [PART_W-1:0]  partition;
		logic [INDEX_W-1:0] byte_index;
		logic [7:0]         byte_value;
	} req_t;

	// Result item.
	typedef struct packed {
		logic [SLOT_W-1:0] slot_number;
		logic              full_res;
	} rsp_t;

	// Outcome of searching one bitmap row for a clear bit.
	typedef struct packed {
		logic              found;
		logic [LANE_W-1:0] lane;
		logic [2:0]        pos;
		logic [7:0]        set_byte;
	} hit_t;

endpackage

// ----- design/bitmap_first_free_allocator_unit.sv -----
// Load item: written to the bitmap at the edge that accepts it, no result.
// Allocate item: one 64-bit bitmap row is read per cycle at the read address shared
// by all lane memories and checked when its data returns; up to ceil(BITMAP_BYTES / 8)
// rows are examined, 1024 by default, and a bad partition skips the scan.
// The input is stalled while an allocation runs, until its result enters the output
// register. Reset clears the control state only; bitmap contents are undefined until
// loaded and get no clearing pass.
module bitmap_first_free_allocator_unit
	import bffa_pkg::*;
#(
	parameter int BITMAP_BYTES    = BITMAP_BYTES_DEF,
	parameter int PARTITION_COUNT = PARTITION_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Geometry: rows of eight bytes per partition, partitions stacked in memory.
	localparam int WPP   = (BITMAP_BYTES + LANES - 1) / LANES;
	localparam int TAIL  = BITMAP_BYTES % LANES;
	localparam int DEPTH = PARTITION_COUNT * WPP;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WIW   = (WPP > 1) ? $clog2(WPP) : 1;
	localparam int WCW   = $clog2(WPP + 1);
	localparam int SCW   = WIW + LANE_W + 4;
	localparam logic [LANES-1:0] TAIL_MASK =
		(TAIL == 0) ? {LANES{1'b1}} : LANES'((1 << TAIL) - 1);
	localparam logic [WIW-1:0] LAST_WORD = WIW'(WPP - 1);
	localparam logic [WCW-1:0] WORD_END  = WCW'(WPP);

	// Controller states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic [AW-1:0]         base_q;
	logic [WCW-1:0]        word_q;
	logic                  pend_s1;
	logic [WIW-1:0]        chk_word_s1;
	rsp_t                  res_q;
	rsp_t                  out_q;
	logic                  out_valid_q;

	logic                  req_acc;
	logic                  part_ok;
	logic                  load_ok;
	logic [AW-1:0]         part_base;
	logic [AW-1:0]         load_addr;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic [7:0]            wdata;
	logic [LANES-1:0]      lane_we;
	logic [LANES-1:0][7:0] row;
	logic [LANES-1:0]      lane_mask;
	logic                  last_chk;
	logic                  stop;
	logic                  issue;
	logic                  out_load;
	logic [SCW-1:0]        slot_wide;
	hit_t                  hit;

	// Input handshake and item decode.
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign part_ok   = (32'(req.partition) < PARTITION_COUNT);
	assign load_ok   = part_ok && (32'(req.byte_index) < BITMAP_BYTES);
	assign part_base = AW'(32'(req.partition) * 32'(WPP));
	assign load_addr = AW'(32'(part_base) + 32'(req.byte_index[INDEX_W-1:LANE_W]));

	// Scan control: a row is issued each cycle and checked when its data returns.
	// The write-back lands before the next item is taken, so reads never overlap it.
	assign raddr     = base_q + AW'(word_q[WIW-1:0]);
	assign last_chk  = (chk_word_s1 == LAST_WORD);
	assign lane_mask = last_chk ? TAIL_MASK : {LANES{1'b1}};
	assign stop      = (state_q == ST_SCAN) && pend_s1 && (hit.found || last_chk);
	assign issue     = (state_q == ST_SCAN) && !stop && (word_q < WORD_END);
	assign slot_wide = SCW'({chk_word_s1, hit.lane, hit.pos}) + SCW'(1);

	bffa_find u_find (
		.row       (row),
		.lane_mask (lane_mask),
		.hit       (hit)
	);

	// Write port: byte loads while idle, the claimed byte at the end of a scan.
	always_comb begin
		lane_we = '0;
		waddr   = load_addr;
		wdata   = req.byte_value;
		if (state_q == ST_IDLE) begin
			if (req_acc && req.operation == OP_LOAD && load_ok) begin
				lane_we[req.byte_index[LANE_W-1:0]] = 1'b1;
			end
		end else begin
			waddr = base_q + AW'(chk_word_s1);
			wdata = hit.set_byte;
			if (stop && hit.found) begin
				lane_we[hit.lane] = 1'b1;
			end
		end
	end

	// One memory per byte lane, all read at the same row.
	for (genvar j = 0; j < LANES; j++) begin : g_lane
		bffa_ram #(
			.WIDTH (8),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (lane_we[j]),
			.waddr (waddr),
			.wdata (wdata),
			.raddr (raddr),
			.rdata (row[j])
		);
	end

	// Controller state and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			word_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					word_q  <= '0;
					if (req_acc && req.operation == OP_ALLOC) begin
						state_q <= part_ok ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					pend_s1 <= issue;
					if (issue) begin
						word_q <= word_q + WCW'(1);
					end
					if (stop) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					pend_s1 <= 1'b0;
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Scan payload: partition base, row under check and the pending result.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_acc) begin
			base_q                <= part_base;
			res_q.slot_number     <= '0;
			res_q.full_res        <= 1'b1;
		end
		if (issue) begin
			chk_word_s1 <= word_q[WIW-1:0];
		end
		if (stop && hit.found) begin
			res_q.slot_number <= SLOT_W'(slot_wide);
			res_q.full_res    <= 1'b0;
		end
	end

	// Output register: takes the finished result once the previous item has left.
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A full report always carries slot zero, and a granted slot is never zero.
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.full_res |-> rsp.slot_number == '0)
		else $error("full result with a non-zero slot");

	a_grant_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.full_res |-> rsp.slot_number != '0)
		else $error("granted result with slot zero");

	// A new result appears only when the controller has just finished an item.
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the finish state");

	// Row data is only checked during a scan.
	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> state_q == ST_SCAN)
		else $error("row check pending outside a scan");

endmodule

// ----- design/bffa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- design/bffa_find.sv -----
// Search of one bitmap row (eight byte lanes) for the first clear bit.
// Depends on bffa_pkg for the lane count and the hit_t struct.
module bffa_find
	import bffa_pkg::*;
(
	input  logic [LANES-1:0][7:0] row,
	input  logic [LANES-1:0]      lane_mask,
	output hit_t                  hit
);

	logic [LANES-1:0] lane_free;
	logic [2:0]       lane_pos [LANES];

	// First clear bit of each lane, counted from the most significant bit.
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			lane_free[j] = 1'b0;
			lane_pos[j]  = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (!row[j][b]) begin
					lane_free[j] = 1'b1;
					lane_pos[j]  = 3'(7 - b);
				end
			end
		end
	end

	// Lowest enabled lane with a clear bit wins; its byte is returned with that bit set.
	always_comb begin
		hit.found    = 1'b0;
		hit.lane     = '0;
		hit.pos      = '0;
		hit.set_byte = '0;
		for (int j = LANES - 1; j >= 0; j--) begin
			if (lane_free[j] && lane_mask[j]) begin
				hit.found    = 1'b1;
				hit.lane     = LANE_W'(j);
				hit.pos      = lane_pos[j];
				hit.set_byte = row[j] | (8'h80 >> lane_pos[j]);
			end
		end
	end

endmodule
